// ===== sv/stgp_pkg.sv =====
// Shared constants and command codes of the group probe engine.
package stgp_pkg;

  localparam int TABLE_LOG2_MAX = 12;
  localparam int TABLE_LOG2_MIN = 3;
  localparam int GROUP_WIDTH    = 8;
  localparam int MAX_CANDIDATES = 64;

  localparam int ADDR_W  = TABLE_LOG2_MAX;
  localparam int BANK_W  = $clog2(GROUP_WIDTH);
  localparam int ROW_W   = ADDR_W - BANK_W;
  localparam int ROWS    = 1 << ROW_W;
  localparam int STRD_W  = ADDR_W + 1;
  localparam int CNT_W   = ADDR_W - BANK_W + 1;
  localparam int NCAND_W = $clog2(MAX_CANDIDATES + 1);
  localparam int LOG2_W  = 4;
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;
  localparam int                FREE_BIT   = 7;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CAND   = 2'd2;

  localparam int USER_HIT = 0;
  localparam int USER_OVF = 1;

endpackage

// ===== sv/swiss_table_group_probe_core.sv =====
// Top level of the group probe engine: banked control byte store and search sequencer.
//
// Channels: the in_ stream carries one command per transaction (write a control
// byte, find an insert slot, find tag candidates); the out_ stream returns result
// transactions, slot in tdata, hit and overflow in tuser, tlast on the final result
// of a command. cfg_ sets table_size_log2 and is always ready; write it only idle.
// A write command gives no result. A search reads each 8-byte group from eight
// byte-wide banks of 512 rows each, so that any unaligned group is read in a
// single memory access. Find insert slot reads one group per cycle until a free
// byte is found or the groups run out, then registers its result for output.
// Find candidates evaluates each group probed, then emits its matching bytes in
// turn; one candidate is held back until the next is known so that tlast is exact.
// At most size/8+1 groups are probed. After reset the store is filled with empty
// bytes, one row a cycle, through all 512 rows, while in_tready stays low.
// A stalled receiver holds the output register; the search then waits at its next
// result, and the next command is taken once the final result is registered.
module swiss_table_group_probe_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // command[1:0], hash[13:2], tag[21:14], write_slot[33:22], write_value[41:34]
  input  logic [stgp_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // slot[11:0]
  output logic [stgp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // hit[0], overflow[1]
  output logic [stgp_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stgp_pkg::LOG2_W-1:0]         cfg_data
);
  import stgp_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR     = 6'b000001,
    ST_IDLE      = 6'b000010,
    ST_EVAL_INS  = 6'b000100,
    ST_EVAL_CAND = 6'b001000,
    ST_EMIT      = 6'b010000,
    ST_FINISH    = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [LOG2_W-1:0]     tsl_r;
  logic [ROW_W-1:0]      clr_row_r, clr_row_nxt;
  logic [ADDR_W-1:0]     pos_r, pos_nxt;
  logic [STRD_W-1:0]     stride_r, stride_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [BYTE_W-1:0]     tag_r, tag_nxt;
  logic [GROUP_WIDTH-1:0] match_r, match_nxt;
  logic                  stop_r, stop_nxt;
  logic [NCAND_W-1:0]    n_r, n_nxt;
  logic                  more_r, more_nxt;
  logic                  hold_valid_r, hold_valid_nxt;
  logic [ADDR_W-1:0]     hold_slot_r, hold_slot_nxt;
  logic [ADDR_W-1:0]     res_slot_r, res_slot_nxt;
  logic                  res_hit_r, res_hit_nxt;
  logic                  res_ovf_r, res_ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]     out_slot_r, out_slot_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [BYTE_W-1:0]     ctrl_mem [GROUP_WIDTH][ROWS];
  logic [BYTE_W-1:0]     rd_data_r [GROUP_WIDTH];
  logic [GROUP_WIDTH-1:0] mem_we;
  logic [ROW_W-1:0]      mem_wrow;
  logic [BYTE_W-1:0]     mem_wdata;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_pos;
  logic [ROW_W-1:0]      rd_row [GROUP_WIDTH];

  logic [CMD_W-1:0]      in_command;
  logic [ADDR_W-1:0]     in_hash;
  logic [BYTE_W-1:0]     in_tag;
  logic [ADDR_W-1:0]     in_write_slot;
  logic [BYTE_W-1:0]     in_write_value;

  logic [LOG2_W-1:0]     l_eff;
  logic [ADDR_W-1:0]     mask;
  logic [CNT_W-1:0]      group_lim;
  logic [STRD_W-1:0]     stride_inc;
  logic [ADDR_W-1:0]     pos_adv;
  logic [BYTE_W-1:0]     grp [GROUP_WIDTH];
  logic [GROUP_WIDTH-1:0] free_mask;
  logic [GROUP_WIDTH-1:0] eq_mask;
  logic                  any_empty;
  logic [BANK_W-1:0]     free_off;
  logic [BANK_W-1:0]     match_off;
  logic                  out_free;
  logic                  in_acc;
  logic                  more_groups;

  assign in_command     = in_tdata[1:0];
  assign in_hash        = in_tdata[13:2];
  assign in_tag         = in_tdata[21:14];
  assign in_write_slot  = in_tdata[33:22];
  assign in_write_value = in_tdata[41:34];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_slot_r);
  assign out_tuser  = {out_ovf_r, out_hit_r};
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    if (tsl_r < LOG2_W'(TABLE_LOG2_MIN)) begin
      l_eff = LOG2_W'(TABLE_LOG2_MIN);
    end else if (tsl_r > LOG2_W'(TABLE_LOG2_MAX)) begin
      l_eff = LOG2_W'(TABLE_LOG2_MAX);
    end else begin
      l_eff = tsl_r;
    end
    mask       = ADDR_W'((STRD_W'(1) << l_eff) - STRD_W'(1));
    group_lim  = CNT_W'(1) << (l_eff - LOG2_W'(BANK_W));
    stride_inc = stride_r + STRD_W'(GROUP_WIDTH);
    pos_adv    = (pos_r + stride_inc[ADDR_W-1:0]) & mask;
  end

  assign more_groups = (count_r < group_lim);

  always_comb begin
    for (int b = 0; b < GROUP_WIDTH; b++) begin
      logic [BANK_W-1:0] off_b;
      logic [ADDR_W-1:0] addr_b;
      off_b     = BANK_W'(b) - rd_pos[BANK_W-1:0];
      addr_b    = (rd_pos + ADDR_W'(off_b)) & mask;
      rd_row[b] = addr_b[ADDR_W-1:BANK_W];
    end
  end

  always_comb begin
    free_off  = '0;
    match_off = '0;
    any_empty = 1'b0;
    for (int o = 0; o < GROUP_WIDTH; o++) begin
      grp[o]       = rd_data_r[BANK_W'(pos_r[BANK_W-1:0] + BANK_W'(o))];
      free_mask[o] = grp[o][FREE_BIT];
      eq_mask[o]   = (grp[o] == tag_r);
      any_empty    = any_empty | (grp[o] == EMPTY_BYTE);
    end
    for (int o = GROUP_WIDTH - 1; o >= 0; o--) begin
      if (free_mask[o]) begin
        free_off = BANK_W'(o);
      end
      if (match_r[o]) begin
        match_off = BANK_W'(o);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_row_nxt    = clr_row_r;
    pos_nxt        = pos_r;
    stride_nxt     = stride_r;
    count_nxt      = count_r;
    tag_nxt        = tag_r;
    match_nxt      = match_r;
    stop_nxt       = stop_r;
    n_nxt          = n_r;
    more_nxt       = more_r;
    hold_valid_nxt = hold_valid_r;
    hold_slot_nxt  = hold_slot_r;
    res_slot_nxt   = res_slot_r;
    res_hit_nxt    = res_hit_r;
    res_ovf_nxt    = res_ovf_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_slot_nxt   = out_slot_r;
    out_hit_nxt    = out_hit_r;
    out_ovf_nxt    = out_ovf_r;
    out_last_nxt   = out_last_r;
    mem_we         = '0;
    mem_wrow       = clr_row_r;
    mem_wdata      = EMPTY_BYTE;
    rd_en          = 1'b0;
    rd_pos         = pos_adv;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = '1;
        clr_row_nxt = clr_row_r + ROW_W'(1);
        if (clr_row_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_pos = in_hash & mask;
        if (in_acc) begin
          case (in_command)
            CMD_WRITE: begin
              mem_we[in_write_slot[BANK_W-1:0]] = 1'b1;
              mem_wrow  = in_write_slot[ADDR_W-1:BANK_W];
              mem_wdata = in_write_value;
            end
            CMD_INSERT, CMD_CAND: begin
              rd_en          = 1'b1;
              pos_nxt        = in_hash & mask;
              stride_nxt     = '0;
              count_nxt      = '0;
              tag_nxt        = in_tag;
              n_nxt          = '0;
              more_nxt       = 1'b0;
              hold_valid_nxt = 1'b0;
              state_nxt      = (in_command == CMD_INSERT) ? ST_EVAL_INS : ST_EVAL_CAND;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EVAL_INS: begin
        if (free_mask != '0) begin
          res_slot_nxt = (pos_r + ADDR_W'(free_off)) & mask;
          res_hit_nxt  = 1'b1;
          res_ovf_nxt  = 1'b0;
          state_nxt    = ST_FINISH;
        end else if (more_groups) begin
          rd_en      = 1'b1;
          pos_nxt    = pos_adv;
          stride_nxt = stride_inc;
          count_nxt  = count_r + CNT_W'(1);
        end else begin
          res_slot_nxt = '0;
          res_hit_nxt  = 1'b0;
          res_ovf_nxt  = 1'b0;
          state_nxt    = ST_FINISH;
        end
      end
      ST_EVAL_CAND: begin
        match_nxt = eq_mask;
        stop_nxt  = any_empty;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (match_r != '0) begin
          if (n_r == NCAND_W'(MAX_CANDIDATES)) begin
            more_nxt  = 1'b1;
            match_nxt = match_r & (match_r - GROUP_WIDTH'(1));
          end else if (!hold_valid_r || out_free) begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_slot_nxt  = hold_slot_r;
              out_hit_nxt   = 1'b1;
              out_ovf_nxt   = 1'b0;
              out_last_nxt  = 1'b0;
            end
            hold_valid_nxt = 1'b1;
            hold_slot_nxt  = (pos_r + ADDR_W'(match_off)) & mask;
            n_nxt          = n_r + NCAND_W'(1);
            match_nxt      = match_r & (match_r - GROUP_WIDTH'(1));
          end
        end else if (stop_r || more_r || !more_groups) begin
          res_slot_nxt = hold_valid_r ? hold_slot_r : '0;
          res_hit_nxt  = hold_valid_r;
          res_ovf_nxt  = hold_valid_r && more_r;
          state_nxt    = ST_FINISH;
        end else begin
          rd_en      = 1'b1;
          pos_nxt    = pos_adv;
          stride_nxt = stride_inc;
          count_nxt  = count_r + CNT_W'(1);
          state_nxt  = ST_EVAL_CAND;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = res_slot_r;
          out_hit_nxt   = res_hit_r;
          out_ovf_nxt   = res_ovf_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < GROUP_WIDTH; b++) begin
      if (mem_we[b]) begin
        ctrl_mem[b][mem_wrow] <= mem_wdata;
      end
      if (rd_en) begin
        rd_data_r[b] <= ctrl_mem[b][rd_row[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      tsl_r       <= LOG2_W'(TABLE_LOG2_MAX);
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tsl_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    stride_r     <= stride_nxt;
    count_r      <= count_nxt;
    tag_r        <= tag_nxt;
    match_r      <= match_nxt;
    stop_r       <= stop_nxt;
    n_r          <= n_nxt;
    more_r       <= more_nxt;
    hold_valid_r <= hold_valid_nxt;
    hold_slot_r  <= hold_slot_nxt;
    res_slot_r   <= res_slot_nxt;
    res_hit_r    <= res_hit_nxt;
    res_ovf_r    <= res_ovf_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hit_r    <= out_hit_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// ===== sv/stgp_checker.sv =====
// Port-level checker for the group probe engine and its bind to the top level.
module stgp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [stgp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [stgp_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);
  import stgp_pkg::*;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("Stalled result transaction changed.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[USER_HIT] |-> out_tlast && (out_tdata == '0))
    else $error("Miss result is not a final zero-slot transaction.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_OVF] |-> out_tuser[USER_HIT] && out_tlast)
    else $error("Overflow flag outside the final candidate.");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready)
    else $error("Commands accepted before the store was cleared.");

endmodule

bind swiss_table_group_probe_core stgp_checker u_stgp_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the group probe engine: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb;
  import stgp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [ADDR_W-1:0] slot;
    logic              hit;
    logic              ovf;
    logic              last;
  } probe_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] hash;
    logic [BYTE_W-1:0] tag;
    logic [ADDR_W-1:0] wslot;
    logic [BYTE_W-1:0] wval;
    bit                typed;
    probe_result_t     want;
  } probe_cmd_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [LOG2_W-1:0] cfg_data;

  logic [BYTE_W-1:0] shadow_store [0:(1<<ADDR_W)-1];
  logic [LOG2_W-1:0] size_log2_reg;
  probe_result_t     step_results[$];
  probe_result_t     pending_results[$];
  probe_cmd_t        queued_rows[$];
  probe_cmd_t        directed[$];
  logic [BYTE_W-1:0] palette [0:3];
  logic [ADDR_W-1:0] focus;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatches = 0;
  int commands_done = 0;
  int results_checked = 0;
  int overflow_runs = 0;
  int cfg_writes = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  swiss_table_group_probe_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  function automatic int unsigned probe_mask();
    int unsigned l;
    l = 32'(size_log2_reg);
    if (l < TABLE_LOG2_MIN) l = TABLE_LOG2_MIN;
    if (l > TABLE_LOG2_MAX) l = TABLE_LOG2_MAX;
    return (1 << l) - 1;
  endfunction

  function automatic void probe_groups(input probe_cmd_t c);
    int unsigned m, groups, pos, stride, n;
    bit more, stop, found;
    logic [BYTE_W-1:0] b;
    probe_result_t r;
    step_results.delete();
    if (c.cmd == CMD_WRITE) begin
      shadow_store[c.wslot] = c.wval;
      return;
    end
    if (c.cmd != CMD_INSERT && c.cmd != CMD_CAND) return;
    m = probe_mask();
    groups = (m + 1) / GROUP_WIDTH + 1;
    pos = 32'(c.hash) & m;
    stride = 0;
    n = 0;
    more = 1'b0;
    stop = 1'b0;
    found = 1'b0;
    for (int p = 0; p < groups && !stop && !found; p++) begin
      for (int o = 0; o < GROUP_WIDTH; o++) begin
        b = shadow_store[(pos + o) & m];
        if (c.cmd == CMD_INSERT) begin
          if (b[FREE_BIT] && !found) begin
            step_results.push_back('{slot: ADDR_W'((pos + o) & m), hit: 1'b1, ovf: 1'b0,
                                     last: 1'b1});
            found = 1'b1;
          end
        end else begin
          if (b == c.tag) begin
            if (n < MAX_CANDIDATES) begin
              step_results.push_back('{slot: ADDR_W'((pos + o) & m), hit: 1'b1, ovf: 1'b0,
                                       last: 1'b0});
              n++;
            end else begin
              more = 1'b1;
            end
          end
          if (b == EMPTY_BYTE) stop = 1'b1;
        end
      end
      stride += GROUP_WIDTH;
      pos = (pos + stride) & m;
    end
    if (step_results.size() == 0) begin
      step_results.push_back('{slot: '0, hit: 1'b0, ovf: 1'b0, last: 1'b1});
    end else if (c.cmd == CMD_CAND) begin
      r = step_results[n-1];
      r.last = 1'b1;
      r.ovf = more;
      step_results[n-1] = r;
    end
  endfunction

  function automatic probe_cmd_t make_row(input logic [CMD_W-1:0] cmd,
                                          input logic [ADDR_W-1:0] hash,
                                          input logic [BYTE_W-1:0] tag,
                                          input logic [ADDR_W-1:0] wslot,
                                          input logic [BYTE_W-1:0] wval,
                                          input bit typed = 1'b0,
                                          input logic [ADDR_W-1:0] slot = '0,
                                          input logic hit = 1'b0);
    probe_cmd_t r;
    r.cmd = cmd;
    r.hash = hash;
    r.tag = tag;
    r.wslot = wslot;
    r.wval = wval;
    r.typed = typed;
    r.want = '{slot: slot, hit: hit, ovf: 1'b0, last: 1'b1};
    return r;
  endfunction

  // Most commands land in a small window so that writes and searches meet.
  function automatic probe_cmd_t random_row();
    probe_cmd_t r;
    int unsigned m, pick;
    m = probe_mask();
    r = make_row(CMD_WRITE, ADDR_W'($urandom), BYTE_W'($urandom), ADDR_W'($urandom),
                 BYTE_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r.cmd = CMD_SPARE;
    end else if (pick < 50) begin
      if ($urandom_range(0, 9) != 0) r.wslot = ADDR_W'((focus + $urandom_range(0, 23)) & m);
      case ($urandom_range(0, 9))
        0: r.wval = EMPTY_BYTE;
        1: r.wval = BYTE_W'($urandom | 32'h80);
        2, 3: r.wval = BYTE_W'($urandom_range(0, 127));
        default: r.wval = palette[$urandom_range(0, 3)];
      endcase
    end else begin
      r.cmd = (pick < 72) ? CMD_INSERT : CMD_CAND;
      if ($urandom_range(0, 6) != 0) r.hash = ADDR_W'((focus + $urandom_range(0, 23)) & m);
      if ($urandom_range(0, 3) != 0) r.tag = palette[$urandom_range(0, 3)];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endtask

  task automatic send_row(input probe_cmd_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    queued_rows.push_back(r);
    in_tdata = {6'b0, r.wval, r.wslot, r.tag, r.hash, r.cmd};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_table_size(input logic [LOG2_W-1:0] value);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0 || queued_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(input int count);
    probe_cmd_t r;
    int done;
    focus = ADDR_W'($urandom);
    for (int i = 0; i < 3; i++) palette[i] = BYTE_W'($urandom_range(0, 127));
    palette[3] = BYTE_W'($urandom_range(128, 254));
    done = 0;
    while (done < count) begin
      r = random_row();
      send_row(r);
      if (r.cmd != CMD_SPARE) done++;
    end
  endtask

  always @(negedge clk) out_tready = ($urandom_range(0, 99) >= receiver_stall_pct);

  always @(posedge clk) begin
    probe_cmd_t sent;
    probe_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        size_log2_reg = cfg_data;
        cfg_writes++;
      end
      if (in_tvalid && in_tready) begin
        sent = queued_rows.pop_front();
        probe_groups(sent);
        if (sent.cmd != CMD_SPARE) commands_done++;
        if (sent.typed) pending_results.push_back(sent.want);
        else foreach (step_results[i]) pending_results.push_back(step_results[i]);
      end
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (out_tuser[USER_OVF]) overflow_runs++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, slot %0d", out_tdata));
        end else begin
          want = pending_results.pop_front();
          if (out_tdata !== {{(OUT_DATA_W-ADDR_W){1'b0}}, want.slot})
            report_mismatch($sformatf("slot %0d, expected %0d", out_tdata, want.slot));
          if (out_tuser[USER_HIT] !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", out_tuser[USER_HIT], want.hit));
          if (out_tuser[USER_OVF] !== want.ovf)
            report_mismatch($sformatf("overflow %b, expected %b", out_tuser[USER_OVF],
                                      want.ovf));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("tlast %b, expected %b", out_tlast, want.last));
        end
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [BYTE_W-1:0] fill_value;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    size_log2_reg = LOG2_W'(TABLE_LOG2_MAX);
    foreach (shadow_store[i]) shadow_store[i] = EMPTY_BYTE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed.push_back(make_row(CMD_INSERT, 12'h000, 8'h00, 12'h000, 8'h00, 1'b1, 12'h000, 1'b1));
    directed.push_back(make_row(CMD_INSERT, 12'hFFF, 8'hFF, 12'hFFF, 8'hFF, 1'b1, 12'hFFF, 1'b1));
    directed.push_back(make_row(CMD_CAND, 12'h000, 8'h00, 12'h000, 8'h00, 1'b1, 12'h000, 1'b0));
    directed.push_back(make_row(CMD_CAND, 12'hFFF, 8'hFF, 12'h000, 8'h00));
    directed.push_back(make_row(CMD_WRITE, 12'hFFF, 8'hFF, 12'hFFF, 8'h00));
    directed.push_back(make_row(CMD_WRITE, 12'h000, 8'h00, 12'h000, 8'h7F));
    directed.push_back(make_row(CMD_WRITE, 12'h000, 8'h00, 12'h001, 8'h80));
    directed.push_back(make_row(CMD_INSERT, 12'hFFF, 8'h00, 12'h000, 8'h00, 1'b1, 12'h001, 1'b1));
    directed.push_back(make_row(CMD_CAND, 12'hFFF, 8'h00, 12'h000, 8'h00));
    directed.push_back(make_row(CMD_CAND, 12'hFFF, 8'h7F, 12'h000, 8'h00));
    directed.push_back(make_row(CMD_SPARE, 12'hFFF, 8'hFF, 12'hFFF, 8'hFF));
    directed.push_back(make_row(CMD_WRITE, 12'h000, 8'h00, 12'h001, 8'h11));
    for (int s = 2; s <= 7; s++)
      directed.push_back(make_row(CMD_WRITE, 12'h000, 8'h00, ADDR_W'(s), 8'h3C));
    directed.push_back(make_row(CMD_INSERT, 12'hFFF, 8'h00, 12'h000, 8'h00));
    directed.push_back(make_row(CMD_CAND, 12'hFFF, 8'h3C, 12'h000, 8'h00));
    directed.push_back(make_row(CMD_WRITE, 12'h000, 8'h00, 12'h800, 8'hFF));
    directed.push_back(make_row(CMD_WRITE, 12'hAAA, 8'h55, 12'h555, 8'hAA));
    directed.push_back(make_row(CMD_CAND, 12'h555, 8'hAA, 12'h000, 8'h00));
    directed.push_back(make_row(CMD_INSERT, 12'h555, 8'h00, 12'h000, 8'h00, 1'b1, 12'h555, 1'b1));
    foreach (directed[i]) send_row(directed[i]);

    write_table_size(LOG2_W'(TABLE_LOG2_MIN));
    sender_idle_pct = 76;
    run_random(35);

    // A fully occupied 64-bucket table gives nine groups of matches, past the result cap.
    write_table_size(4'd6);
    sender_idle_pct = 0;
    receiver_stall_pct = 76;
    fill_value = BYTE_W'($urandom_range(0, 127));
    for (int s = 0; s < 64; s++)
      send_row(make_row(CMD_WRITE, ADDR_W'($urandom), BYTE_W'($urandom), ADDR_W'(s),
                        fill_value));
    send_row(make_row(CMD_CAND, ADDR_W'($urandom), fill_value, 12'h000, 8'h00));
    send_row(make_row(CMD_INSERT, ADDR_W'($urandom), fill_value, 12'h000, 8'h00));
    run_random(14);

    write_table_size(4'd15);
    sender_idle_pct = 22;
    receiver_stall_pct = 22;
    run_random(30);

    write_table_size(4'd0);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    run_random(30);

    write_table_size(4'd4);
    receiver_stall_pct = 76;
    run_random(35);

    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4 * SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d commands and %0d checked results; %0d candidate runs hit the cap.",
             commands_done, results_checked, overflow_runs);
    $display("Table size written %0d times, clamped and in range, over four stall patterns.",
             cfg_writes);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/stgp_pkg.sv
sv/swiss_table_group_probe_core.sv
sv/stgp_checker.sv
dv/tb.sv
